// File: rtl/pcrc_pkg.sv
// Package with shared constants, register indexes and control types for the CRC engine.
`default_nettype none

package pcrc_pkg;

  localparam int DEF_MAX_CRC_WIDTH = 32;
  localparam int CFG_DATA_W        = 32;
  localparam int CFG_IDX_W         = 3;
  localparam int CRC_OUT_W         = 32;
  localparam int BYTE_W            = 8;
  localparam int WIDTH_FIELD_W     = 6;
  localparam int MIN_CRC_WIDTH     = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CRC_WIDTH      = 3'd0;
  localparam cfg_idx_t CFG_POLYNOMIAL     = 3'd1;
  localparam cfg_idx_t CFG_INITIAL_VALUE  = 3'd2;
  localparam cfg_idx_t CFG_REFLECT_INPUT  = 3'd3;
  localparam cfg_idx_t CFG_REFLECT_OUTPUT = 3'd4;
  localparam cfg_idx_t CFG_FINAL_XOR      = 3'd5;

  localparam logic [WIDTH_FIELD_W-1:0] RST_CRC_WIDTH = 6'd32;
  localparam logic [CFG_DATA_W-1:0]    RST_POLYNOMIAL = 32'h04C1_1DB7;
  localparam logic [CFG_DATA_W-1:0]    RST_INITIAL    = 32'hFFFF_FFFF;
  localparam logic                     RST_REFLECT_IN  = 1'b1;
  localparam logic                     RST_REFLECT_OUT = 1'b1;
  localparam logic [CFG_DATA_W-1:0]    RST_FINAL_XOR  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic reflect_in;
    logic reflect_out;
  } pcrc_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/pcrc_datapath.sv
// Byte-wide CRC update (eight shift-XOR steps) and result finishing logic.
`default_nettype none

module pcrc_datapath #(
  parameter int MAX_CRC_WIDTH = pcrc_pkg::DEF_MAX_CRC_WIDTH,
  parameter int WW            = $clog2(MAX_CRC_WIDTH + 1)
) (
  input  wire logic [MAX_CRC_WIDTH-1:0]       crc_i,
  input  wire logic [pcrc_pkg::BYTE_W-1:0]    data_i,
  input  wire pcrc_pkg::pcrc_ctrl_t           ctrl_i,
  input  wire logic [WW-1:0]                  width_i,
  input  wire logic [MAX_CRC_WIDTH-1:0]       poly_i,
  input  wire logic [MAX_CRC_WIDTH-1:0]       final_i,
  input  wire logic [MAX_CRC_WIDTH-1:0]       mask_i,
  output logic      [MAX_CRC_WIDTH-1:0]       crc_o,
  output logic      [pcrc_pkg::CRC_OUT_W-1:0] result_o
);
  import pcrc_pkg::*;

  localparam int IW = $clog2(MAX_CRC_WIDTH);

  logic [IW-1:0]            top_idx;
  logic [BYTE_W-1:0]        byte_in;
  logic [MAX_CRC_WIDTH-1:0] rev_crc;
  logic [MAX_CRC_WIDTH-1:0] fin_crc;

  assign top_idx = IW'(width_i - WW'(1));

  always_comb begin
    for (int i = 0; i < BYTE_W; i++) begin
      byte_in[i] = ctrl_i.reflect_in ? data_i[BYTE_W-1-i] : data_i[i];
    end
  end

  always_comb begin
    logic [MAX_CRC_WIDTH-1:0] r;
    logic                     fb;
    r = crc_i & mask_i;
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      fb = r[top_idx] ^ byte_in[k];
      r  = (r << 1) & mask_i;
      if (fb) begin
        r = r ^ poly_i;
      end
    end
    crc_o = r;
  end

  always_comb begin
    int idx;
    for (int i = 0; i < MAX_CRC_WIDTH; i++) begin
      idx = int'(width_i) - 1 - i;
      if (i < int'(width_i)) begin
        rev_crc[i] = crc_o[IW'(idx)];
      end else begin
        rev_crc[i] = 1'b0;
      end
    end
  end

  assign fin_crc  = ((ctrl_i.reflect_out ? rev_crc : crc_o) ^ final_i) & mask_i;
  assign result_o = CRC_OUT_W'(fin_crc);

endmodule

`default_nettype wire

// File: rtl/parameterized_crc_engine_unit.sv
// Top level of the configurable byte-serial CRC engine with stream ports.
//
//   Channel  Direction  Handshake            Payload
//   in_      slave      in_tvalid/in_tready  in_tdata[7:0] data_byte, in_tlast last_byte
//   out_     master     out_tvalid/out_tready out_tdata[31:0] crc_value
//   cfg_     write      cfg_we               cfg_addr index, cfg_wdata value
//
// One byte is taken per cycle while in_tready is high; the running CRC register updates in the cycle of
// the transfer. The CRC appears on out_ in the cycle after the transfer of the last byte.
// The output register holds a pending result; in_tready is low only while it is
// full and out_tready is low. Reset restores all register defaults.
`default_nettype none

module parameterized_crc_engine_unit #(
  parameter int MAX_CRC_WIDTH = pcrc_pkg::DEF_MAX_CRC_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [pcrc_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  input  wire logic                            in_tlast,   // last_byte
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [pcrc_pkg::CRC_OUT_W-1:0]  out_tdata,  // [31:0] crc_value
  input  wire logic                            cfg_we,
  input  wire logic [pcrc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [pcrc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pcrc_pkg::*;

  localparam int MAXW = MAX_CRC_WIDTH;
  localparam int WW   = $clog2(MAXW + 1);

  function automatic logic [WW-1:0] eff_width(logic [WIDTH_FIELD_W-1:0] w);
    logic [WW-1:0] r;
    if (int'(w) < MIN_CRC_WIDTH) begin
      r = WW'(MIN_CRC_WIDTH);
    end else if (int'(w) > MAXW) begin
      r = WW'(MAXW);
    end else begin
      r = WW'(w);
    end
    return r;
  endfunction

  function automatic logic [MAXW-1:0] width_mask(logic [WW-1:0] w);
    logic [MAXW-1:0] m;
    for (int i = 0; i < MAXW; i++) begin
      m[i] = (i < int'(w));
    end
    return m;
  endfunction

  logic [WIDTH_FIELD_W-1:0] width_r, width_nxt;
  logic [CFG_DATA_W-1:0]    poly_r, poly_nxt;
  logic [CFG_DATA_W-1:0]    init_r, init_nxt;
  logic [CFG_DATA_W-1:0]    fxor_r, fxor_nxt;
  pcrc_ctrl_t               ctrl_r, ctrl_nxt;
  logic                     cfg_hit;

  logic [MAXW-1:0]      crc_r, crc_nxt;
  logic [MAXW-1:0]      step_crc;
  logic [CRC_OUT_W-1:0] step_result;
  logic [MAXW-1:0]      reload_val;
  logic [WW-1:0]        cur_w;
  logic [MAXW-1:0]      cur_mask;

  logic                 out_valid_r, out_valid_nxt;
  logic [CRC_OUT_W-1:0] out_data_r;
  logic                 in_fire;
  logic                 done_fire;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign done_fire  = in_fire && in_tlast;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    width_nxt = width_r;
    poly_nxt  = poly_r;
    init_nxt  = init_r;
    fxor_nxt  = fxor_r;
    ctrl_nxt  = ctrl_r;
    cfg_hit   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CRC_WIDTH: begin
          width_nxt = cfg_wdata[WIDTH_FIELD_W-1:0];
          cfg_hit   = 1'b1;
        end
        CFG_POLYNOMIAL: begin
          poly_nxt = cfg_wdata;
          cfg_hit  = 1'b1;
        end
        CFG_INITIAL_VALUE: begin
          init_nxt = cfg_wdata;
          cfg_hit  = 1'b1;
        end
        CFG_REFLECT_INPUT: begin
          ctrl_nxt.reflect_in = cfg_wdata[0];
          cfg_hit             = 1'b1;
        end
        CFG_REFLECT_OUTPUT: begin
          ctrl_nxt.reflect_out = cfg_wdata[0];
          cfg_hit              = 1'b1;
        end
        CFG_FINAL_XOR: begin
          fxor_nxt = cfg_wdata;
          cfg_hit  = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  assign cur_w      = eff_width(width_r);
  assign cur_mask   = width_mask(cur_w);
  assign reload_val = MAXW'(init_nxt) & width_mask(eff_width(width_nxt));

  pcrc_datapath #(
    .MAX_CRC_WIDTH(MAXW),
    .WW           (WW)
  ) u_datapath (
    .crc_i   (crc_r),
    .data_i  (in_tdata),
    .ctrl_i  (ctrl_r),
    .width_i (cur_w),
    .poly_i  (MAXW'(poly_r) & cur_mask),
    .final_i (MAXW'(fxor_r)),
    .mask_i  (cur_mask),
    .crc_o   (step_crc),
    .result_o(step_result)
  );

  always_comb begin
    crc_nxt = crc_r;
    if (cfg_hit || done_fire) begin
      crc_nxt = reload_val;
    end else if (in_fire) begin
      crc_nxt = step_crc;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= RST_CRC_WIDTH;
      poly_r      <= RST_POLYNOMIAL;
      init_r      <= RST_INITIAL;
      fxor_r      <= RST_FINAL_XOR;
      ctrl_r      <= '{reflect_in: RST_REFLECT_IN, reflect_out: RST_REFLECT_OUT};
      crc_r       <= MAXW'(RST_INITIAL) & width_mask(eff_width(RST_CRC_WIDTH));
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      poly_r      <= poly_nxt;
      init_r      <= init_nxt;
      fxor_r      <= fxor_nxt;
      ctrl_r      <= ctrl_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_data_r <= step_result;
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> out_tvalid)
    else $error("last byte transfer did not produce a result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_tlast && out_tvalid && out_tready) |=> !out_tvalid)
    else $error("result appeared without a last byte");

  a_reload_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (done_fire && !cfg_hit) |=> (crc_r == $past(reload_val)))
    else $error("CRC register not reloaded after last byte");

  a_idle_holds_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_fire && !cfg_hit) |=> $stable(crc_r))
    else $error("CRC register changed without a transfer or write");

endmodule

`default_nettype wire

// File: sim/tb_parameterized_crc_engine_unit.sv
// Self-checking stream testbench for the configurable byte-serial CRC engine.
`default_nettype none

module tb_parameterized_crc_engine_unit;
  import pcrc_pkg::*;

  localparam int       MAX_W         = DEF_MAX_CRC_WIDTH;
  localparam int       NUM_ITEMS     = 850;
  localparam int       CALM_AFTER    = 720;
  localparam int       STALL_LIMIT   = 1000;
  localparam int       NUM_PRESETS   = 12;
  localparam int       MAX_PRINTS    = 100;
  localparam cfg_idx_t CFG_UNUSED_6  = 3'd6;
  localparam cfg_idx_t CFG_UNUSED_7  = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [WIDTH_FIELD_W-1:0] width;
    logic [CFG_DATA_W-1:0]    poly;
    logic [CFG_DATA_W-1:0]    init;
    logic                     refl_in;
    logic                     refl_out;
    logic [CFG_DATA_W-1:0]    xor_out;
  } crc_setting_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [CRC_OUT_W-1:0]  out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  parameterized_crc_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  byte_item_t           byte_queue[$];
  logic [CRC_OUT_W-1:0] crc_expected[$];

  int n_queued      = 0;
  int n_accepted    = 0;
  int n_results     = 0;
  int n_cfg_writes  = 0;
  int n_settings    = 0;
  int errors        = 0;
  int stall_cycles  = 0;
  int in_idle_pct   = 0;
  int out_idle_pct  = 0;
  int in_gap        = 0;
  int out_gap       = 0;
  bit in_xfer       = 1'b0;

  logic [WIDTH_FIELD_W-1:0] crc_width_reg;
  logic [CFG_DATA_W-1:0]    crc_poly_reg;
  logic [CFG_DATA_W-1:0]    crc_init_reg;
  logic                     crc_refl_in_reg;
  logic                     crc_refl_out_reg;
  logic [CFG_DATA_W-1:0]    crc_xor_reg;
  logic [63:0]              crc_running;

  function automatic int unsigned crc_eff_width();
    int unsigned w;
    w = {26'd0, crc_width_reg};
    if (w < MIN_CRC_WIDTH) w = MIN_CRC_WIDTH;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic logic [63:0] crc_mask(input int unsigned w);
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [63:0] bit_reverse(input logic [63:0] v, input int unsigned n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < n; i++) begin
      r = {r[62:0], v[0]};
      v = v >> 1;
    end
    return r;
  endfunction

  function automatic void crc_reload();
    crc_running = {32'd0, crc_init_reg} & crc_mask(crc_eff_width());
  endfunction

  function automatic void crc_model_reset();
    crc_width_reg    = RST_CRC_WIDTH;
    crc_poly_reg     = RST_POLYNOMIAL;
    crc_init_reg     = RST_INITIAL;
    crc_refl_in_reg  = RST_REFLECT_IN;
    crc_refl_out_reg = RST_REFLECT_OUT;
    crc_xor_reg      = RST_FINAL_XOR;
    crc_reload();
  endfunction

  function automatic void crc_model_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_CRC_WIDTH:      crc_width_reg    = val[WIDTH_FIELD_W-1:0];
      CFG_POLYNOMIAL:     crc_poly_reg     = val;
      CFG_INITIAL_VALUE:  crc_init_reg     = val;
      CFG_REFLECT_INPUT:  crc_refl_in_reg  = val[0];
      CFG_REFLECT_OUTPUT: crc_refl_out_reg = val[0];
      CFG_FINAL_XOR:      crc_xor_reg      = val;
      default:            return;
    endcase
    crc_reload();
  endfunction

  function automatic bit crc_model_byte(input logic [7:0] data, input logic last,
                                        output logic [CRC_OUT_W-1:0] crc_out);
    int unsigned w;
    logic [63:0] mask;
    logic [63:0] poly;
    logic [63:0] r;
    logic [7:0]  b;
    logic        fb;
    w    = crc_eff_width();
    mask = crc_mask(w);
    poly = {32'd0, crc_poly_reg} & mask;
    r    = crc_running & mask;
    b    = data;
    crc_out = '0;
    if (crc_refl_in_reg) b = 8'(bit_reverse({56'd0, data}, 8));
    for (int i = 7; i >= 0; i--) begin
      fb = r[w-1] ^ b[i];
      r  = (r << 1) & mask;
      if (fb) r = r ^ poly;
    end
    crc_running = r;
    if (!last) return 1'b0;
    if (crc_refl_out_reg) r = bit_reverse(r, w);
    r = (r ^ {32'd0, crc_xor_reg}) & mask;
    crc_out = r[31:0];
    crc_reload();
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (errors < MAX_PRINTS)
      $display("MISMATCH %s: got %08h expected %08h", what, got, want);
    errors++;
  endtask

  // Monitor and predictor.
  always @(posedge clk) begin
    logic [CRC_OUT_W-1:0] crc_pred;
    if (!rst_n) begin
      crc_model_reset();
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_tvalid && in_tready;
      if (cfg_we) begin
        crc_model_write(cfg_addr, cfg_wdata);
        n_cfg_writes++;
      end
      if (in_tvalid && in_tready) begin
        n_accepted++;
        if (crc_model_byte(in_tdata, in_tlast, crc_pred)) crc_expected.push_back(crc_pred);
      end
      if (out_tvalid && out_tready) begin
        n_results++;
        if (crc_expected.size() == 0) begin
          flag_mismatch("unexpected result", out_tdata, '0);
        end else begin
          crc_pred = crc_expected.pop_front();
          if (out_tdata !== crc_pred) flag_mismatch("crc_value", out_tdata, crc_pred);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // Driver for both stream sides.
  always @(negedge clk) begin
    byte_item_t item;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_xfer) begin
        if (in_gap > 0) begin
          in_tvalid <= 1'b0;
          in_gap--;
        end else if (byte_queue.size() > 0) begin
          item = byte_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= item.data;
          in_tlast  <= item.last;
          if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct)
            in_gap = $urandom_range(1, 13);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap--;
      end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_tready <= 1'b0;
        out_gap = $urandom_range(1, 13) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic crc_setting_t preset_setting(input int k);
    crc_setting_t s;
    case (k)
      0:  s = {6'd32, 32'h04C11DB7, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF};
      1:  s = {6'd16, 32'h00001021, 32'h0000FFFF, 1'b0, 1'b0, 32'h00000000};
      2:  s = {6'd16, 32'h00008005, 32'h00000000, 1'b1, 1'b1, 32'h00000000};
      3:  s = {6'd16, 32'h00003D65, 32'h00000000, 1'b1, 1'b1, 32'h0000FFFF};
      4:  s = {6'd8,  32'h00000007, 32'h00000000, 1'b0, 1'b0, 32'h00000000};
      5:  s = {6'd8,  32'h00000031, 32'h00000000, 1'b1, 1'b1, 32'h00000000};
      6:  s = {6'd5,  32'h00000005, 32'h0000001F, 1'b1, 1'b1, 32'h0000001F};
      7:  s = {6'd7,  32'h00000009, 32'h00000000, 1'b0, 1'b0, 32'h00000000};
      8:  s = {6'd4,  32'h00000003, 32'h00000000, 1'b1, 1'b1, 32'h00000000};
      9:  s = {6'd6,  32'h00000003, 32'h00000000, 1'b1, 1'b1, 32'h00000000};
      10: s = {6'd32, 32'h04C11DB7, 32'hFFFFFFFF, 1'b0, 1'b0, 32'h00000000};
      default: s = {6'd16, 32'h00001021, 32'h00000000, 1'b1, 1'b1, 32'h00000000};
    endcase
    return s;
  endfunction

  function automatic crc_setting_t random_setting();
    crc_setting_t s;
    case ($urandom_range(0, 9))
      0:       s.width = 6'($urandom_range(0, 3));
      1:       s.width = 6'($urandom_range(33, 63));
      2:       s.width = 6'd32;
      3:       s.width = 6'd4;
      default: s.width = 6'($urandom_range(4, 32));
    endcase
    s.poly     = $urandom;
    s.init     = $urandom;
    s.refl_in  = 1'($urandom_range(0, 1));
    s.refl_out = 1'($urandom_range(0, 1));
    s.xor_out  = $urandom;
    return s;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_setting(input crc_setting_t s);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CFG_CRC_WIDTH, {junk[31:6], s.width});
    write_reg(CFG_POLYNOMIAL, s.poly);
    write_reg(CFG_INITIAL_VALUE, s.init);
    junk = $urandom;
    write_reg(CFG_REFLECT_INPUT, {junk[31:1], s.refl_in});
    junk = $urandom;
    write_reg(CFG_REFLECT_OUTPUT, {junk[31:1], s.refl_out});
    write_reg(CFG_FINAL_XOR, s.xor_out);
    n_settings++;
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic last);
    byte_item_t item;
    item.data = data;
    item.last = last;
    byte_queue.push_back(item);
    n_queued++;
  endtask

  task automatic queue_message(input int len, input bit terminated);
    for (int i = 0; i < len; i++)
      queue_byte(pick_byte(), terminated && (i == len - 1));
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || crc_expected.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 2))
      0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
      1: begin in_idle_pct = 10; out_idle_pct = 5;  end
      default: begin in_idle_pct = 35; out_idle_pct = 20; end
    endcase
  endtask

  initial begin
    int    n_msgs;
    int    len;
    string chk;
    chk = "123456789";
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    pick_idling();

    // Check string with the reset setting, then single-byte extremes, then two bytes without a last byte.
    foreach (chk[i]) queue_byte(chk[i], i == 8);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'h3C, 1'b0);
    wait_idle();
    // An unknown register index must leave the running CRC alone.
    write_reg(CFG_UNUSED_6, $urandom);
    queue_byte(8'h5A, 1'b1);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'h22, 1'b0);
    wait_idle();
    // Any known register write restarts the message; oversize and undersize widths clamp.
    write_reg(CFG_CRC_WIDTH, 32'hFFFF_FFFF);
    queue_byte(8'hFF, 1'b1);
    wait_idle();
    write_reg(CFG_CRC_WIDTH, 32'd0);
    write_reg(CFG_POLYNOMIAL, 32'h0000_0003);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    wait_idle();
    write_reg(CFG_CRC_WIDTH, 32'd3);
    queue_byte(8'h80, 1'b1);
    wait_idle();
    write_reg(CFG_CRC_WIDTH, 32'd33);
    write_reg(CFG_UNUSED_7, $urandom);
    queue_byte(8'h55, 1'b1);
    wait_idle();
    load_setting(preset_setting(6));
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    wait_idle();

    while (n_queued < NUM_ITEMS) begin
      if (n_queued >= CALM_AFTER) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        pick_idling();
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: load_setting(preset_setting($urandom_range(0, NUM_PRESETS - 1)));
        4, 5, 6:    load_setting(random_setting());
        7:          write_reg(cfg_idx_t'($urandom_range(0, 5)), $urandom);
        default:    write_reg($urandom_range(0, 1) ? CFG_UNUSED_6 : CFG_UNUSED_7, $urandom);
      endcase
      n_msgs = $urandom_range(3, 12);
      for (int m = 0; m < n_msgs; m++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        queue_message(len, 1'b1);
      end
      if ($urandom_range(0, 6) == 0) queue_message($urandom_range(1, 5), 1'b0);
      wait_idle();
    end

    wait_idle();
    repeat (4) @(negedge clk);
    while (crc_expected.size() != 0)
      flag_mismatch("missing result", '0, crc_expected.pop_front());
    $display("Sent %0d bytes and checked %0d CRC results.", n_accepted, n_results);
    $display("Made %0d register writes across %0d full settings, presets and random.",
             n_cfg_writes, n_settings);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/pcrc_pkg.sv
rtl/pcrc_datapath.sv
rtl/parameterized_crc_engine_unit.sv
sim/tb_parameterized_crc_engine_unit.sv
